// File: sv/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg: shared types and constants for the label region statistics unit
// Field widths, operation and register codes, and the per-label entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

	// Field widths
	localparam int unsigned LABEL_W    = 16;
	localparam int unsigned COORD_W    = 12;
	localparam int unsigned COORD_BITS = 12;
	localparam int unsigned AREA_W     = 25;
	localparam int unsigned SUM_W      = 36;
	localparam int unsigned FEAT_W     = 16;
	localparam int unsigned OUT_LBL_W  = 8;
	localparam int unsigned BOX_W      = COORD_W + 1;
	localparam int unsigned FILL_W     = 9;
	localparam int unsigned CFG_W      = AREA_W;
	localparam int unsigned CFG_IDX_W  = 3;

	// Stream word widths
	localparam int unsigned S_DATA_W = 40;
	localparam int unsigned S_USER_W = 2;
	localparam int unsigned M_DATA_W = 176;
	localparam int unsigned M_USER_W = 1;

	// Default table depth
	localparam int unsigned MAX_LABELS_DEF = 256;

	// Feature filter is waived at this multiple of the minimum area
	localparam int unsigned FEAT_RELAX = 5;

	localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << COORD_BITS) - 1);

	// Output word bit offsets
	localparam int unsigned OFS_AREA   = 8;
	localparam int unsigned OFS_LEFT   = 33;
	localparam int unsigned OFS_TOP    = 45;
	localparam int unsigned OFS_RIGHT  = 57;
	localparam int unsigned OFS_BOTTOM = 69;
	localparam int unsigned OFS_COLSUM = 81;
	localparam int unsigned OFS_ROWSUM = 117;
	localparam int unsigned OFS_FEAT   = 153;

	typedef enum logic [1:0] {
		OP_PIXEL    = 2'd0,
		OP_KEYPOINT = 2'd1,
		OP_READOUT  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AREA_MIN       = 3'd0,
		CFG_FEATURE_MIN    = 3'd1,
		CFG_BOX_MIN_WIDTH  = 3'd2,
		CFG_BOX_MIN_HEIGHT = 3'd3,
		CFG_FILL_RATIO_MIN = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [AREA_W-1:0]  area;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
		logic [SUM_W-1:0]   colsum;
		logic [SUM_W-1:0]   rowsum;
		logic [FEAT_W-1:0]  feat;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		area:   '0,
		left:   COORD_MASK,
		top:    COORD_MASK,
		right:  '0,
		bottom: '0,
		colsum: '0,
		rowsum: '0,
		feat:   '0
	};

endpackage

`default_nettype wire

// File: sv/label_region_statistics_unit.sv
// ----------------------------------------------------------------------------
// label_region_statistics_unit: per-label area, box, sums and feature count
// Pixel and keypoint words update one table entry by read-modify-write;
// a readout word returns the entry with a filter verdict and clears it.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tuser: operation; tdata: label, pos_x, pos_y
//   m_*      out  m_tvalid/m_tready  tuser: accepted; tdata: region statistics
//   cfg_*    in   cfg_we             cfg_index selects register, cfg_wdata value
//
// One word per cycle is taken while the result side is not stalled. A readout
// result passes through stage 1 (table read and entry update), stage 2 (base
// filter checks with the box size product) and stage 3 (fill ratio product
// and compare) into the output register before it shows on m_tvalid.
// Back-to-back words for one label use a forwarding path around the
// registered table read. A stalled result freezes the whole pipeline and
// drops s_tready. After reset a clearing pass writes every entry, one per
// cycle, with s_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module label_region_statistics_unit
	import lrs_pkg::*;
#(
	parameter int unsigned MAX_LABELS = MAX_LABELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // label[15:0], pos_x[27:16], pos_y[39:28]
	input  logic [S_USER_W-1:0]  s_tuser,   // operation[1:0]
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,   // region_label[7:0], region_area[32:8],
	                                        // box_left[44:33], box_top[56:45],
	                                        // box_right[68:57], box_bottom[80:69],
	                                        // column_sum[116:81], row_sum[152:117],
	                                        // feature_count[168:153], zero fill
	output logic [M_USER_W-1:0]  m_tuser,   // accepted[0]
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int unsigned IDX_W = $clog2(MAX_LABELS);
	localparam logic [LABEL_W-1:0] LABEL_LIMIT = LABEL_W'(MAX_LABELS);
	localparam logic [IDX_W-1:0]   IDX_LAST    = IDX_W'(MAX_LABELS - 1);
	localparam int unsigned AMIN5_W = AREA_W + 3;
	localparam int unsigned WH_W    = 2 * BOX_W;
	localparam int unsigned FP_W    = WH_W + FILL_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [AREA_W-1:0] area_min_q;
	logic [FEAT_W-1:0] feat_min_q;
	logic [BOX_W-1:0]  box_min_w_q;
	logic [BOX_W-1:0]  box_min_h_q;
	logic [FILL_W-1:0] fill_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_min_q  <= '0;
			feat_min_q  <= '0;
			box_min_w_q <= '0;
			box_min_h_q <= '0;
			fill_min_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_AREA_MIN:       area_min_q  <= cfg_wdata;
				CFG_FEATURE_MIN:    feat_min_q  <= cfg_wdata[FEAT_W-1:0];
				CFG_BOX_MIN_WIDTH:  box_min_w_q <= cfg_wdata[BOX_W-1:0];
				CFG_BOX_MIN_HEIGHT: box_min_h_q <= cfg_wdata[BOX_W-1:0];
				CFG_FILL_RATIO_MIN: fill_min_q  <= cfg_wdata[FILL_W-1:0];
				default: ; // unused index: drop the write
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Entry update for pixel and keypoint words; readout clears the entry
	// ------------------------------------------------------------------
	function automatic entry_t entry_update(entry_t cur, op_t op,
	                                        logic [COORD_W-1:0] x,
	                                        logic [COORD_W-1:0] y);
		entry_t          nxt;
		logic [SUM_W:0]  csum;
		logic [SUM_W:0]  rsum;
		nxt  = cur;
		csum = {1'b0, cur.colsum} + (SUM_W+1)'(x);
		rsum = {1'b0, cur.rowsum} + (SUM_W+1)'(y);
		unique case (op)
			OP_PIXEL: begin
				if (cur.area != '1) nxt.area = cur.area + AREA_W'(1);
				if (x < cur.left)   nxt.left   = x;
				if (y < cur.top)    nxt.top    = y;
				if (x > cur.right)  nxt.right  = x;
				if (y > cur.bottom) nxt.bottom = y;
				nxt.colsum = csum[SUM_W] ? '1 : csum[SUM_W-1:0];
				nxt.rowsum = rsum[SUM_W] ? '1 : rsum[SUM_W-1:0];
			end
			OP_KEYPOINT: begin
				if (cur.feat != '1) nxt.feat = cur.feat + FEAT_W'(1);
			end
			OP_READOUT: nxt = ENTRY_RESET;
			default: nxt = cur;
		endcase
		return nxt;
	endfunction

	// ------------------------------------------------------------------
	// Input decode
	// ------------------------------------------------------------------
	logic               adv;       // whole pipeline moves this cycle
	logic               accept;
	logic               clr_busy_q;
	logic [IDX_W-1:0]   clr_cnt_q;
	op_t                in_op;
	logic [LABEL_W-1:0] in_label;
	logic [COORD_W-1:0] in_x;
	logic [COORD_W-1:0] in_y;
	logic [IDX_W-1:0]   in_idx;
	logic               op_known;
	logic               in_live;
	logic               m_tvalid_q;

	assign in_op    = op_t'(s_tuser);
	assign in_label = s_tdata[LABEL_W-1:0];
	assign in_x     = s_tdata[LABEL_W +: COORD_W] & COORD_MASK;
	assign in_y     = s_tdata[LABEL_W+COORD_W +: COORD_W] & COORD_MASK;
	assign in_idx   = in_label[IDX_W-1:0];

	always_comb begin
		unique case (in_op)
			OP_PIXEL, OP_KEYPOINT, OP_READOUT: op_known = 1'b1;
			default:                           op_known = 1'b0;
		endcase
	end

	// a negative label reads as a large unsigned value and fails the limit too
	assign in_live  = op_known && (in_label < LABEL_LIMIT);
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv && !clr_busy_q;
	assign accept   = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// Clearing pass after reset
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + IDX_W'(1);
			if (clr_cnt_q == IDX_LAST) clr_busy_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: table read data present, update computed, write back
	// ------------------------------------------------------------------
	logic               valid_s1;
	op_t                op_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	entry_t             rd_data_q;
	entry_t             fwd_data_q;
	logic               fwd_q;
	entry_t             cur_s1;
	entry_t             new_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			if (adv) valid_s1 <= accept && in_live;
			// the entry written by stage 1 at this edge is not yet in the table
			if (accept) fwd_q <= valid_s1 && (idx_s1 == in_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= in_op;
			idx_s1     <= in_idx;
			x_s1       <= in_x;
			y_s1       <= in_y;
			fwd_data_q <= new_s1;
		end
	end

	assign cur_s1 = fwd_q ? fwd_data_q : rd_data_q;
	assign new_s1 = entry_update(cur_s1, op_s1, x_s1, y_s1);

	// ------------------------------------------------------------------
	// Statistics table: one write port, one registered read port
	// ------------------------------------------------------------------
	entry_t           stat_mem [MAX_LABELS];
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	entry_t           mem_wd;

	assign mem_we = clr_busy_q || (valid_s1 && adv);
	assign mem_wa = clr_busy_q ? clr_cnt_q : idx_s1;
	assign mem_wd = clr_busy_q ? ENTRY_RESET : new_s1;

	always_ff @(posedge clk) begin
		if (mem_we) stat_mem[mem_wa] <= mem_wd;
		if (accept) rd_data_q <= stat_mem[in_idx];
	end

	// ------------------------------------------------------------------
	// Stage 2: base filter checks and box size product
	// ------------------------------------------------------------------
	logic              valid_s2;
	entry_t            ent_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [BOX_W-1:0]  w_s2;
	logic [BOX_W-1:0]  h_s2;
	logic [AMIN5_W-1:0] amin5_s2;
	logic              feat_fail_s2;
	logic              ok_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && (op_s1 == OP_READOUT);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s2 <= cur_s1;
			idx_s2 <= idx_s1;
		end
	end

	assign w_s2     = {1'b0, ent_s2.right} - {1'b0, ent_s2.left} + BOX_W'(1);
	assign h_s2     = {1'b0, ent_s2.bottom} - {1'b0, ent_s2.top} + BOX_W'(1);
	assign amin5_s2 = AMIN5_W'(area_min_q) + {1'b0, area_min_q, 2'b00};
	assign feat_fail_s2 = (feat_min_q != '0) && (ent_s2.feat < feat_min_q)
	                      && (AMIN5_W'(ent_s2.area) < amin5_s2);
	assign ok_s2 = (ent_s2.area != '0) && (ent_s2.area >= area_min_q) && !feat_fail_s2
	               && (ent_s2.right >= ent_s2.left) && (ent_s2.bottom >= ent_s2.top)
	               && (w_s2 >= box_min_w_q) && (h_s2 >= box_min_h_q);

	// ------------------------------------------------------------------
	// Stage 3: fill ratio test, area * 256 against ratio * width * height
	// ------------------------------------------------------------------
	logic             valid_s3;
	entry_t           ent_s3;
	logic [IDX_W-1:0] idx_s3;
	logic             ok_s3;
	logic [WH_W-1:0]  wh_s3;
	logic [FP_W-1:0]  fill_prod;
	logic [FP_W-1:0]  area_scaled;
	logic             fill_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s3 <= ent_s2;
			idx_s3 <= idx_s2;
			ok_s3  <= ok_s2;
			wh_s3  <= WH_W'(w_s2) * WH_W'(h_s2);
		end
	end

	assign fill_prod   = FP_W'(fill_min_q) * FP_W'(wh_s3);
	assign area_scaled = FP_W'({ent_s3.area, 8'h00});
	assign fill_ok     = area_scaled >= fill_prod;

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic [M_DATA_W-1:0] m_tdata_q;
	logic [M_USER_W-1:0] m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s3) begin
			m_tdata_q <= {7'b0, ent_s3.feat, ent_s3.rowsum, ent_s3.colsum,
			              ent_s3.bottom, ent_s3.right, ent_s3.top, ent_s3.left,
			              ent_s3.area, OUT_LBL_W'(idx_s3)};
			m_tuser_q <= M_USER_W'(ok_s3 && fill_ok);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// File: sv/lrs_checker.sv
// ----------------------------------------------------------------------------
// lrs_checker: port-level checks for the label region statistics unit
// Watches the result stream for verdicts that contradict the reported entry.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_checker
	import lrs_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_DATA_W-1:0]  m_tdata,
	input logic [M_USER_W-1:0]  m_tuser
);

	logic [AREA_W-1:0]  area;
	logic [COORD_W-1:0] left;
	logic [COORD_W-1:0] top;
	logic [COORD_W-1:0] right;
	logic [COORD_W-1:0] bottom;
	logic [SUM_W-1:0]   colsum;
	logic [SUM_W-1:0]   rowsum;

	assign area   = m_tdata[OFS_AREA +: AREA_W];
	assign left   = m_tdata[OFS_LEFT +: COORD_W];
	assign top    = m_tdata[OFS_TOP +: COORD_W];
	assign right  = m_tdata[OFS_RIGHT +: COORD_W];
	assign bottom = m_tdata[OFS_BOTTOM +: COORD_W];
	assign colsum = m_tdata[OFS_COLSUM +: SUM_W];
	assign rowsum = m_tdata[OFS_ROWSUM +: SUM_W];

	// hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// a passing region is nonempty with an ordered box
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> area != '0 && right >= left && bottom >= top)
		else $error("accepted region is empty or has an inverted box");

	// an empty region shows cleared contents and fails
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && area == '0 |-> !m_tuser[0] && left == COORD_MASK
		&& top == COORD_MASK && right == '0 && bottom == '0
		&& colsum == '0 && rowsum == '0)
		else $error("empty region does not read as cleared");

	// the clearing pass holds off input right after reset
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !s_tready && !m_tvalid)
		else $error("input taken before the table was cleared");

endmodule

bind label_region_statistics_unit lrs_checker u_lrs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for label_region_statistics_unit
// Drives pixel, keypoint and readout words into the input stream and checks
// every result word against an in-bench copy of the per-label tables and the
// region filters. A short table of directed words comes first: reset
// contents, coordinate extremes, ignored labels and the unused operation.
// Six random phases follow, each under its own filter setting. Sender
// bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import lrs_pkg::*;

	// Operation code with no function in the block
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int unsigned          N_LABELS        = MAX_LABELS_DEF;
	localparam int unsigned          WAIVER_FACTOR   = 5;
	localparam logic [COORD_W-1:0]   COORD_TOP       = '1;
	localparam longint unsigned      SUM_LIMIT       = 64'hF_FFFF_FFFF;
	localparam int                   ITEMS_PER_PHASE = 325;
	localparam int                   N_PHASES        = 6;
	localparam int                   HOLD_CYCLES     = 400;
	// leave margin for the pipeline to empty before a register write or the end
	localparam int                   SETTLE_CYCLES   = 12;
	localparam int                   DRAIN_CYCLES    = 16;
	localparam int                   LIMIT_CYCLES    = 2_000_000;

	typedef struct packed {
		logic [OUT_LBL_W-1:0] label;
		logic                 accepted;
		logic [AREA_W-1:0]    area;
		logic [COORD_W-1:0]   left;
		logic [COORD_W-1:0]   top;
		logic [COORD_W-1:0]   right;
		logic [COORD_W-1:0]   bottom;
		logic [SUM_W-1:0]     colsum;
		logic [SUM_W-1:0]     rowsum;
		logic [FEAT_W-1:0]    feat;
	} region_stats_t;

	typedef struct {
		logic [1:0]         op;
		logic [LABEL_W-1:0] lbl;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		bit                 known;
		region_stats_t      want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;
	logic [S_USER_W-1:0]  s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;
	logic [M_USER_W-1:0]  m_tuser;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	label_region_statistics_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the per-label tables
	logic [AREA_W-1:0]  tbl_area   [N_LABELS];
	logic [COORD_W-1:0] tbl_left   [N_LABELS];
	logic [COORD_W-1:0] tbl_top    [N_LABELS];
	logic [COORD_W-1:0] tbl_right  [N_LABELS];
	logic [COORD_W-1:0] tbl_bottom [N_LABELS];
	logic [SUM_W-1:0]   tbl_colsum [N_LABELS];
	logic [SUM_W-1:0]   tbl_rowsum [N_LABELS];
	logic [FEAT_W-1:0]  tbl_feat   [N_LABELS];

	// Shadow copy of the filter registers
	longint unsigned flt_area_min;
	longint unsigned flt_feature_min;
	longint unsigned flt_box_w;
	longint unsigned flt_box_h;
	longint unsigned flt_fill;

	region_stats_t stats_due [$];
	stim_row_t     plan [$];
	region_stats_t seen_stats;
	int            mismatches;
	int            burst_left;
	int            cycle_cnt;
	bit            hold_req;
	int            hold_left;
	int            stall_mode;
	int            stall_left;
	int            center_x [N_LABELS];
	int            center_y [N_LABELS];

	// Clock: 2 ns period
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic void clear_region(int unsigned k);
		tbl_area[k]   = '0;
		tbl_left[k]   = COORD_TOP;
		tbl_top[k]    = COORD_TOP;
		tbl_right[k]  = '0;
		tbl_bottom[k] = '0;
		tbl_colsum[k] = '0;
		tbl_rowsum[k] = '0;
		tbl_feat[k]   = '0;
	endfunction

	function automatic bit passes_filters(int unsigned k);
		longint unsigned a;
		longint unsigned w;
		longint unsigned h;
		a = tbl_area[k];
		if (a == 0 || a < flt_area_min)
			return 1'b0;
		// keypoint filter is waived for regions well above the minimum area
		if (flt_feature_min != 0 && tbl_feat[k] < flt_feature_min &&
		    a < flt_area_min * WAIVER_FACTOR)
			return 1'b0;
		if (tbl_right[k] < tbl_left[k] || tbl_bottom[k] < tbl_top[k])
			return 1'b0;
		w = longint'(tbl_right[k]) - longint'(tbl_left[k]) + 1;
		h = longint'(tbl_bottom[k]) - longint'(tbl_top[k]) + 1;
		if (flt_box_w != 0 && w < flt_box_w)
			return 1'b0;
		if (flt_box_h != 0 && h < flt_box_h)
			return 1'b0;
		// fill ratio in unsigned Q1.8, compared exactly without division
		if (flt_fill != 0 && a * 256 < flt_fill * w * h)
			return 1'b0;
		return 1'b1;
	endfunction

	// Apply one accepted word to the tables; return 1 with the readout stats
	function automatic bit update_regions(input logic [1:0] op,
		input logic [LABEL_W-1:0] lbl, input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, output region_stats_t res);
		int unsigned     k;
		longint unsigned s;
		res = '0;
		// negative or beyond the table: ignored by every operation
		if (lbl[LABEL_W-1] || lbl >= N_LABELS)
			return 1'b0;
		k = lbl;
		case (op)
		OP_PIXEL: begin
			if (tbl_area[k] != '1)
				tbl_area[k] = tbl_area[k] + 1'b1;
			if (x < tbl_left[k])   tbl_left[k]   = x;
			if (y < tbl_top[k])    tbl_top[k]    = y;
			if (x > tbl_right[k])  tbl_right[k]  = x;
			if (y > tbl_bottom[k]) tbl_bottom[k] = y;
			s = longint'(tbl_colsum[k]) + longint'(x);
			tbl_colsum[k] = (s > SUM_LIMIT) ? SUM_LIMIT : s;
			s = longint'(tbl_rowsum[k]) + longint'(y);
			tbl_rowsum[k] = (s > SUM_LIMIT) ? SUM_LIMIT : s;
			return 1'b0;
		end
		OP_KEYPOINT: begin
			if (tbl_feat[k] != '1)
				tbl_feat[k] = tbl_feat[k] + 1'b1;
			return 1'b0;
		end
		OP_READOUT: begin
			res.label    = k[OUT_LBL_W-1:0];
			res.accepted = passes_filters(k);
			res.area     = tbl_area[k];
			res.left     = tbl_left[k];
			res.top      = tbl_top[k];
			res.right    = tbl_right[k];
			res.bottom   = tbl_bottom[k];
			res.colsum   = tbl_colsum[k];
			res.rowsum   = tbl_rowsum[k];
			res.feat     = tbl_feat[k];
			clear_region(k);
			return 1'b1;
		end
		default: return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Directed table helpers
	// ------------------------------------------------------------------------
	function automatic region_stats_t make_stats(int lbl, bit acc, int area,
		int l, int t, int r, int b, longint cs, longint rs, int feat);
		region_stats_t st;
		st.label    = OUT_LBL_W'(lbl);
		st.accepted = acc;
		st.area     = AREA_W'(area);
		st.left     = COORD_W'(l);
		st.top      = COORD_W'(t);
		st.right    = COORD_W'(r);
		st.bottom   = COORD_W'(b);
		st.colsum   = SUM_W'(cs);
		st.rowsum   = SUM_W'(rs);
		st.feat     = FEAT_W'(feat);
		return st;
	endfunction

	// Cleared entry: box shows left/top all ones, right/bottom zero
	function automatic region_stats_t empty_stats(int lbl);
		return make_stats(lbl, 1'b0, 0, 4095, 4095, 0, 0, 0, 0, 0);
	endfunction

	function automatic void add_row(logic [1:0] op, int lbl, int x, int y,
		bit known, region_stats_t want);
		stim_row_t row;
		row.op    = op;
		row.lbl   = LABEL_W'(lbl);
		row.x     = COORD_W'(x);
		row.y     = COORD_W'(y);
		row.known = known;
		row.want  = want;
		plan.insert(plan.size(), row);
	endfunction

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	// Offer one word; burst/gap pattern decides whether to idle first.
	// Enter and leave at a falling edge.
	task automatic send_word(input logic [1:0] op, input logic [LABEL_W-1:0] lbl,
		input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
		input bit known, input region_stats_t known_stats);
		region_stats_t res;
		int            gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {y, x, lbl};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// word taken at this edge: advance the predictor
		if (update_regions(op, lbl, x, y, res))
			stats_due.insert(stats_due.size(), known ? known_stats : res);
		@(negedge clk);
	endtask

	// Drop valid, wait for every pending result, then let the pipe empty
	task automatic settle_results();
		s_tvalid <= 1'b0;
		while (stats_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	// Write all five filter registers back to back, block idle
	task automatic program_filters(longint unsigned a, longint unsigned f,
		longint unsigned w, longint unsigned h, longint unsigned r);
		write_reg(CFG_AREA_MIN, CFG_W'(a));
		write_reg(CFG_FEATURE_MIN, CFG_W'(f));
		write_reg(CFG_BOX_MIN_WIDTH, CFG_W'(w));
		write_reg(CFG_BOX_MIN_HEIGHT, CFG_W'(h));
		write_reg(CFG_FILL_RATIO_MIN, CFG_W'(r));
		cfg_we <= 1'b0;
		flt_area_min    = a & 64'h1FF_FFFF;
		flt_feature_min = f & 64'hFFFF;
		flt_box_w       = w & 64'h1FFF;
		flt_box_h       = h & 64'h1FFF;
		flt_fill        = r & 64'h1FF;
	endtask

	// ------------------------------------------------------------------------
	// Receiver: own stall pattern, plus one long hold-off on request
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(5, 60);
			end
			stall_left--;
			case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 9) < 7);
			default: m_tready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------------
	function automatic void check_field(string name, longint unsigned want,
		longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_stats.label    = m_tdata[OUT_LBL_W-1:0];
			seen_stats.accepted = m_tuser[0];
			seen_stats.area     = m_tdata[OFS_AREA +: AREA_W];
			seen_stats.left     = m_tdata[OFS_LEFT +: COORD_W];
			seen_stats.top      = m_tdata[OFS_TOP +: COORD_W];
			seen_stats.right    = m_tdata[OFS_RIGHT +: COORD_W];
			seen_stats.bottom   = m_tdata[OFS_BOTTOM +: COORD_W];
			seen_stats.colsum   = m_tdata[OFS_COLSUM +: SUM_W];
			seen_stats.rowsum   = m_tdata[OFS_ROWSUM +: SUM_W];
			seen_stats.feat     = m_tdata[OFS_FEAT +: FEAT_W];
			if (stats_due.size() == 0) begin
				$error("result word for label %0d with none pending", seen_stats.label);
				mismatches++;
			end else begin
				check_field("region_label", stats_due[0].label, seen_stats.label);
				check_field("accepted", stats_due[0].accepted, seen_stats.accepted);
				check_field("region_area", stats_due[0].area, seen_stats.area);
				check_field("box_left", stats_due[0].left, seen_stats.left);
				check_field("box_top", stats_due[0].top, seen_stats.top);
				check_field("box_right", stats_due[0].right, seen_stats.right);
				check_field("box_bottom", stats_due[0].bottom, seen_stats.bottom);
				check_field("column_sum", stats_due[0].colsum, seen_stats.colsum);
				check_field("row_sum", stats_due[0].rowsum, seen_stats.rowsum);
				check_field("feature_count", stats_due[0].feat, seen_stats.feat);
				void'(stats_due.pop_front());
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int                 ph;
		int                 r;
		int                 q;
		int                 focus [4];
		logic [1:0]         op;
		logic [LABEL_W-1:0] lbl;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;

		// hold every input at a known value from time zero
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		m_tready   = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_AREA_MIN;
		cfg_wdata  = '0;
		mismatches = 0;
		burst_left = 0;
		cycle_cnt  = 0;
		hold_req   = 1'b0;
		hold_left  = 0;
		stall_mode = 0;
		stall_left = 0;
		flt_area_min    = 0;
		flt_feature_min = 0;
		flt_box_w       = 0;
		flt_box_h       = 0;
		flt_fill        = 0;
		for (int k = 0; k < N_LABELS; k++)
			clear_region(k);

		// Directed words. Typed results hold under the reset filter values.
		// reset contents at both ends of the table
		add_row(OP_READOUT, 0, 0, 0, 1'b1, empty_stats(0));
		add_row(OP_READOUT, 255, 4095, 4095, 1'b1, empty_stats(255));
		// coordinate extremes plus one keypoint on label 0
		add_row(OP_PIXEL, 0, 0, 0, 1'b0, '0);
		add_row(OP_PIXEL, 0, 4095, 4095, 1'b0, '0);
		add_row(OP_KEYPOINT, 0, 0, 0, 1'b0, '0);
		add_row(OP_READOUT, 0, 0, 0, 1'b1,
			make_stats(0, 1'b1, 2, 0, 0, 4095, 4095, 4095, 4095, 1));
		// negative and out-of-range labels: ignored, no result
		add_row(OP_PIXEL, -1, 1, 1, 1'b0, '0);
		add_row(OP_PIXEL, -32768, 2, 2, 1'b0, '0);
		add_row(OP_PIXEL, 256, 3, 3, 1'b0, '0);
		add_row(OP_PIXEL, 32767, 4, 4, 1'b0, '0);
		add_row(OP_KEYPOINT, -1, 0, 0, 1'b0, '0);
		add_row(OP_READOUT, -1, 0, 0, 1'b0, '0);
		add_row(OP_READOUT, 256, 0, 0, 1'b0, '0);
		// unused operation
		add_row(OP_UNUSED, 1, 3, 3, 1'b0, '0);
		// none of the above may alias onto a real entry
		add_row(OP_READOUT, 0, 0, 0, 1'b1, empty_stats(0));
		add_row(OP_READOUT, 255, 0, 0, 1'b1, empty_stats(255));
		add_row(OP_READOUT, 1, 0, 0, 1'b1, empty_stats(1));
		// single-pixel region
		add_row(OP_PIXEL, 255, 5, 7, 1'b0, '0);
		add_row(OP_READOUT, 255, 0, 0, 1'b1,
			make_stats(255, 1'b1, 1, 5, 7, 5, 7, 5, 7, 0));
		// back-to-back words on one label can hit the forwarding path
		add_row(OP_PIXEL, 3, 10, 20, 1'b0, '0);
		add_row(OP_PIXEL, 3, 2, 30, 1'b0, '0);
		add_row(OP_KEYPOINT, 3, 4095, 0, 1'b0, '0);
		add_row(OP_READOUT, 3, 0, 0, 1'b0, '0);
		// keypoints but no pixels: empty region, not accepted
		add_row(OP_KEYPOINT, 4, 0, 0, 1'b0, '0);
		add_row(OP_READOUT, 4, 0, 0, 1'b0, '0);

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// walk the table; the clearing pass holds s_tready low meanwhile
		foreach (plan[i])
			send_word(plan[i].op, plan[i].lbl, plan[i].x, plan[i].y,
				plan[i].known, plan[i].want);

		// random phases, each under its own filter setting
		for (ph = 0; ph < N_PHASES; ph++) begin
			settle_results();
			case (ph)
			0: program_filters(0, 0, 0, 0, 0);
			1: program_filters(3, 2, 2, 2, 64);
			3: program_filters(16777216, 65535, 4096, 4096, 256);
			4: program_filters(1, 65535, 1, 1, 256);
			default: program_filters($urandom_range(1, 12), $urandom_range(1, 5),
				$urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 256));
			endcase

			// a few busy labels per phase so regions grow between readouts
			foreach (focus[i])
				focus[i] = $urandom_range(0, N_LABELS - 1);
			if (ph % 2 == 1) begin
				focus[0] = 0;
				focus[3] = N_LABELS - 1;
			end
			for (int k = 0; k < N_LABELS; k++) begin
				center_x[k] = ($urandom_range(0, 9) == 0) ? 4080 : $urandom_range(0, 4080);
				center_y[k] = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 4080);
			end

			// stall the result side for a long stretch while words keep coming
			if (ph == 2)
				hold_req = 1'b1;

			repeat (ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 68)      op = OP_PIXEL;
				else if (r < 82) op = OP_KEYPOINT;
				else if (r < 97) op = OP_READOUT;
				else             op = OP_UNUSED;

				q = $urandom_range(0, 99);
				if (q < 75)
					lbl = LABEL_W'(focus[$urandom_range(0, 3)]);
				else if (q < 93)
					lbl = LABEL_W'($urandom_range(0, N_LABELS - 1));
				else if (q < 97)
					lbl = LABEL_W'($urandom_range(N_LABELS, 32767));
				else
					lbl = LABEL_W'(-$urandom_range(1, 32768));

				if (op == OP_PIXEL && $urandom_range(0, 3) != 0) begin
					x = COORD_W'(center_x[lbl[7:0]] + $urandom_range(0, 15));
					y = COORD_W'(center_y[lbl[7:0]] + $urandom_range(0, 15));
				end else begin
					x = COORD_W'($urandom);
					y = COORD_W'($urandom);
				end
				send_word(op, lbl, x, y, 1'b0, '0);
			end
		end

		settle_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
